@@ sv/pfs_pkg.sv @@
// Package with sizes, request codes and controller command types for the palette scan-out.
`default_nettype none
package pfs_pkg;

    localparam int SRC_WIDTH    = 160;
    localparam int SRC_HEIGHT   = 160;
    localparam int NUM_BUFFERS  = 2;
    localparam int FRAME_PIXELS = SRC_WIDTH * SRC_HEIGHT;
    localparam int FB_DEPTH     = NUM_BUFFERS * FRAME_PIXELS;
    localparam int FB_AW        = $clog2(FB_DEPTH);
    localparam int POS_W        = $clog2(FRAME_PIXELS + 1);
    localparam int COL_W        = $clog2(SRC_WIDTH + 1);
    localparam int BUF_W        = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef logic [1:0] t_req;
    localparam t_req REQ_PAL_WR = 2'd0;
    localparam t_req REQ_FB_WR  = 2'd1;
    localparam t_req REQ_STEP   = 2'd2;

    typedef struct packed {
        logic pal_wr;
        logic fb_wr;
        logic step;
        logic load_out;
    } t_pfs_cmd;

endpackage
`default_nettype wire

@@ sv/pfs_ctrl.sv @@
// Controller state machine that sequences beats through the scan-out datapath.
`default_nettype none
module pfs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire pfs_pkg::t_req     i_req,
    output logic                   o_ready,
    input  wire logic              i_m_tready,
    output logic                   o_m_tvalid,
    output pfs_pkg::t_pfs_cmd      o_cmd
);
    import pfs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAL,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    assign o_ready    = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign accept     = i_valid && o_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.pal_wr   = accept && (i_req == REQ_PAL_WR);
        o_cmd.fb_wr    = accept && (i_req == REQ_FB_WR);
        o_cmd.step     = accept && (i_req == REQ_STEP);
        o_cmd.load_out = (r_state == S_OUT) && (!r_out_valid || i_m_tready);
        n_state        = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.step) begin
                    n_state = S_PAL;
                end
            end
            S_PAL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

@@ sv/pfs_datapath.sv @@
// Datapath with palette and framebuffer memories, scan counters and the output register.
`default_nettype none
module pfs_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pfs_pkg::t_pfs_cmd             i_cmd,
    input  wire logic                          i_buffer_select,
    input  wire logic [7:0]                    i_entry_index,
    input  wire logic [14:0]                   i_pixel_address,
    input  wire logic [15:0]                   i_write_value,
    output logic [15:0]                        o_pixel_color,
    output logic                               o_end_of_frame
);
    import pfs_pkg::*;

    logic [15:0] r_palette [256];
    logic [7:0]  r_frame [FB_DEPTH];

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic             r_row;
    logic             n_row;
    logic             r_pix;
    logic             n_pix;
    logic             r_active;
    logic             n_active;
    logic [BUF_W-1:0] r_buf;
    logic [BUF_W-1:0] eff_buf;
    logic             n_eof;

    logic [7:0]       r_fb_q;
    logic             r_eof_q;
    logic [15:0]      r_pal_q;
    logic [15:0]      r_out_color;
    logic             r_out_eof;

    logic [POS_W-1:0] pos_dec;
    logic [FB_AW-1:0] rd_addr;
    logic [FB_AW-1:0] wr_addr;
    logic             wr_ok;

    assign o_pixel_color  = r_out_color;
    assign o_end_of_frame = r_out_eof;

    always_comb begin
        if (r_active) begin
            eff_buf = r_buf;
        end else if (32'(i_buffer_select) < NUM_BUFFERS) begin
            eff_buf = BUF_W'(i_buffer_select);
        end else begin
            eff_buf = '0;
        end
        pos_dec = r_pos - POS_W'(1);
        rd_addr = FB_AW'(FB_AW'(eff_buf) * FB_AW'(FRAME_PIXELS)) + FB_AW'(pos_dec);
        wr_addr = FB_AW'(FB_AW'(i_buffer_select) * FB_AW'(FRAME_PIXELS))
                + FB_AW'(i_pixel_address);
        wr_ok   = (32'(i_buffer_select) < NUM_BUFFERS)
               && (32'(i_pixel_address) < FRAME_PIXELS);

        n_pos    = r_pos;
        n_col    = r_col;
        n_row    = r_row;
        n_pix    = 1'b1;
        n_active = 1'b1;
        n_eof    = 1'b0;
        if (r_pix) begin
            n_pix = 1'b0;
            n_pos = pos_dec;
            n_col = r_col - COL_W'(1);
            if (r_col == COL_W'(1)) begin
                n_col = COL_W'(SRC_WIDTH);
                if (!r_row) begin
                    n_row = 1'b1;
                    n_pos = pos_dec + POS_W'(SRC_WIDTH);
                end else begin
                    n_row = 1'b0;
                end
            end
            if (n_pos == '0) begin
                n_eof    = 1'b1;
                n_pos    = POS_W'(FRAME_PIXELS);
                n_row    = 1'b0;
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_W'(FRAME_PIXELS);
            r_col    <= COL_W'(SRC_WIDTH);
            r_row    <= 1'b0;
            r_pix    <= 1'b0;
            r_active <= 1'b0;
            r_buf    <= '0;
        end else if (i_cmd.step) begin
            r_pos    <= n_pos;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pix    <= n_pix;
            r_active <= n_active;
            r_buf    <= eff_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fb_wr && wr_ok) begin
            r_frame[wr_addr] <= i_write_value[7:0];
        end
        if (i_cmd.step) begin
            r_fb_q  <= r_frame[rd_addr];
            r_eof_q <= n_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr) begin
            r_palette[i_entry_index] <= i_write_value;
        end
        r_pal_q <= r_palette[r_fb_q];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_color <= r_pal_q;
            r_out_eof   <= r_eof_q;
        end
    end

endmodule
`default_nettype wire

@@ sv/palette_framebuffer_2x_scanout.sv @@
// A step beat's pixel passes the framebuffer read register, the palette read register and the
// output register before it is valid on the master side. The slave side stays ready after a
// write beat; after a step beat it stays not ready until the output register load, and the load
// waits while an earlier pixel is still held by a stalled master.
// Reset clears the scan to the start of a frame with no buffer latched; the palette
// and framebuffer memories are not cleared and hold no defined data until written.
`default_nettype none
module palette_framebuffer_2x_scanout (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // buffer_select[0], entry_index[8:1], pixel_address[23:9], write_value[39:24]
    input  wire logic [pfs_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                       i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // pixel_color[15:0]
    output logic [pfs_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    output logic                                  o_m_tlast
);
    import pfs_pkg::*;

    t_pfs_cmd cmd;

    pfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_req      (i_s_tuser),
        .o_ready    (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    pfs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_buffer_select (i_s_tdata[0]),
        .i_entry_index   (i_s_tdata[8:1]),
        .i_pixel_address (i_s_tdata[23:9]),
        .i_write_value   (i_s_tdata[39:24]),
        .o_pixel_color   (o_m_tdata),
        .o_end_of_frame  (o_m_tlast)
    );

`ifndef SYNTHESIS
    a_step_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |=> !o_s_tready)
        else $error("Step beat did not block the slave side.");

    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.pal_wr || cmd.fb_wr) |=> o_s_tready)
        else $error("Write beat took more than one cycle.");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_m_tvalid)
        else $error("Output load did not raise tvalid.");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.pal_wr, cmd.fb_wr, cmd.step}))
        else $error("More than one command issued in a cycle.");
`endif

endmodule
`default_nettype wire
